### design/arpc_pkg.sv
// Shared types and constants for the ARP cache with expiry.
// Used by arpc_cmp, arpc_seq and the top module; depends on nothing else.
package arpc_pkg;

  // Store geometry
  localparam int ENTRIES = 8;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int SLOT_W  = 3;

  // Operation kinds
  localparam logic [1:0] KIND_LOOKUP   = 2'd0;
  localparam logic [1:0] KIND_REMEMBER = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;

  // Register map
  localparam int          PADDR_W      = 3;
  localparam logic        REG_LIFETIME = 1'b0;
  localparam logic [31:0] LIFETIME_RST = 32'd60000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ip_address;
    logic [47:0] hw_address;
    logic [63:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [47:0]       found_mac;
    logic [SLOT_W-1:0] slot;
  } out_word_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [63:0] expiry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic             accept;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             cmp_vld;
    logic [IDX_W-1:0] cmp_idx;
    logic             wr_en;
    logic             out_load;
  } seq_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic stop;
    logic remember;
  } seq_stat_t;

  // Shared compare unit result
  typedef struct packed {
    logic ip_eq;
    logic lt;
  } cmp_res_t;

endpackage

### design/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### design/arpc_cmp.sv
// Shared compare unit: address equality and 64-bit unsigned less-than.
// Uses arpc_pkg for the result type.
module arpc_cmp (
  input  logic [31:0]       ip_a,
  input  logic [31:0]       ip_b,
  input  logic [63:0]       val_a,
  input  logic [63:0]       val_b,
  output arpc_pkg::cmp_res_t res
);

  // one equality and one magnitude compare per cycle
  always_comb begin
    res.ip_eq = (ip_a == ip_b);
    res.lt    = (val_a < val_b);
  end

endmodule

### design/arpc_seq.sv
// Sequencer: walks the store one entry per cycle through the compare unit.
// Uses arpc_pkg for states, control and status structs.
module arpc_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_kind,
  input  arpc_pkg::seq_stat_t  stat,
  input  logic                 out_free,
  output logic                 in_stall,
  output arpc_pkg::seq_ctrl_t  ctrl
);

  arpc_pkg::state_t                state_r, state_nxt;
  logic [arpc_pkg::CNT_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                            cmp_vld_r, cmp_vld_nxt;
  logic [arpc_pkg::IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic                            issue;
  logic                            last;
  logic                            scan_kind;

  assign scan_kind = (in_kind == arpc_pkg::KIND_LOOKUP) ||
                     (in_kind == arpc_pkg::KIND_REMEMBER);
  assign issue = (state_r == arpc_pkg::ST_SCAN) &&
                 (scan_idx_r < arpc_pkg::CNT_W'(arpc_pkg::ENTRIES));
  assign last  = cmp_vld_r &&
                 (stat.stop ||
                  (cmp_idx_r == arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arpc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = scan_kind ? arpc_pkg::ST_SCAN : arpc_pkg::ST_DONE;
        end
      end
      arpc_pkg::ST_SCAN: begin
        if (last) begin
          state_nxt = stat.remember ? arpc_pkg::ST_WRITE : arpc_pkg::ST_DONE;
        end
      end
      arpc_pkg::ST_WRITE: state_nxt = arpc_pkg::ST_DONE;
      arpc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = arpc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = arpc_pkg::ST_IDLE;
    endcase
  end

  // scan counters
  always_comb begin
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    if (state_r == arpc_pkg::ST_IDLE) begin
      scan_idx_nxt = '0;
    end else if (state_r == arpc_pkg::ST_SCAN) begin
      cmp_vld_nxt  = issue && !last;
      cmp_idx_nxt  = scan_idx_r[arpc_pkg::IDX_W-1:0];
      scan_idx_nxt = scan_idx_r + arpc_pkg::CNT_W'(issue);
    end
  end

  // outputs
  always_comb begin
    in_stall      = (state_r != arpc_pkg::ST_IDLE);
    ctrl.accept   = (state_r == arpc_pkg::ST_IDLE) && in_valid;
    ctrl.rd_en    = issue;
    ctrl.rd_addr  = scan_idx_r[arpc_pkg::IDX_W-1:0];
    ctrl.cmp_vld  = cmp_vld_r;
    ctrl.cmp_idx  = cmp_idx_r;
    ctrl.wr_en    = (state_r == arpc_pkg::ST_WRITE);
    ctrl.out_load = (state_r == arpc_pkg::ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= arpc_pkg::ST_IDLE;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      cmp_idx_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      cmp_idx_r  <= cmp_idx_nxt;
    end
  end

endmodule

### design/arp_cache_with_expiry.sv
// ARP cache with expiry: maps IPv4 addresses to MAC addresses in an eight-entry
// store, each entry with a 64-bit expiry in milliseconds. A word is taken only
// while the block is idle. Lookup and remember scan the store one entry per
// cycle through a single shared compare unit, behind a RAM with registered read
// data. A lookup ends its scan early on a hit, a remember then writes its entry,
// and clear or an unused kind skips the scan. Reset and clear empty the store at
// once through per-entry valid bits, so no clearing pass is needed.
// The result register lets a new word be accepted while a result waits.
// Depends on arpc_pkg, arpc_ram, arpc_cmp and arpc_seq.
module arp_cache_with_expiry (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  arpc_pkg::in_word_t             in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output arpc_pkg::out_word_t            out_data,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [arpc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  arpc_pkg::seq_ctrl_t              ctrl;
  arpc_pkg::seq_stat_t              stat;
  arpc_pkg::cmp_res_t               cmp;
  arpc_pkg::in_word_t               req_r;
  arpc_pkg::entry_t                 rd_entry;
  arpc_pkg::entry_t                 cur;
  arpc_pkg::entry_t                 wr_entry;
  arpc_pkg::out_word_t              out_data_r;
  logic [arpc_pkg::ENTRY_W-1:0]     rd_data;
  logic [arpc_pkg::ENTRIES-1:0]     valid_r, valid_nxt;
  logic [31:0]                      lifetime_r;
  logic [64:0]                      exp_sum;
  logic [63:0]                      exp_new_r;
  logic [63:0]                      min_exp_r;
  logic [arpc_pkg::IDX_W-1:0]       best_r;
  logic                             hit_r;
  logic [47:0]                      mac_r;
  logic [arpc_pkg::SLOT_W-1:0]      slot_r;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_free;
  logic                             is_lookup;
  logic [63:0]                      cmp_a, cmp_b;
  logic                             cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[arpc_pkg::PADDR_W-1] == arpc_pkg::REG_LIFETIME);
  assign prdata = (paddr[arpc_pkg::PADDR_W-1] == arpc_pkg::REG_LIFETIME) ?
                  lifetime_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= arpc_pkg::LIFETIME_RST;
    end else if (cfg_wr) begin
      lifetime_r <= pwdata;
    end
  end

  // sequencer
  assign out_free = !out_valid_r || !out_stall;

  arpc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .stat     (stat),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  // entry store
  assign wr_entry.ip     = req_r.ip_address;
  assign wr_entry.mac    = req_r.hw_address;
  assign wr_entry.expiry = exp_new_r;

  arpc_ram #(
    .WIDTH (arpc_pkg::ENTRY_W),
    .DEPTH (arpc_pkg::ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ctrl.wr_en),
    .wr_addr (best_r),
    .wr_data (wr_entry),
    .rd_en   (ctrl.rd_en),
    .rd_addr (ctrl.rd_addr),
    .rd_data (rd_data)
  );

  // an entry never written since reset or clear reads as zero
  assign rd_entry = rd_data;
  assign cur      = valid_r[ctrl.cmp_idx] ? rd_entry : '0;

  // shared compare: now < expiry for lookup, expiry < running minimum otherwise
  assign is_lookup = (req_r.kind == arpc_pkg::KIND_LOOKUP);
  assign cmp_a     = is_lookup ? req_r.now_ms : cur.expiry;
  assign cmp_b     = is_lookup ? cur.expiry : min_exp_r;

  arpc_cmp u_cmp (
    .ip_a  (cur.ip),
    .ip_b  (req_r.ip_address),
    .val_a (cmp_a),
    .val_b (cmp_b),
    .res   (cmp)
  );

  assign stat.remember = (req_r.kind == arpc_pkg::KIND_REMEMBER);
  assign stat.stop     = ctrl.cmp_vld && cmp.ip_eq && (!is_lookup || cmp.lt);

  // saturating expiry for remember
  assign exp_sum = {1'b0, in_data.now_ms} + {33'd0, lifetime_r};

  // request and scan registers
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      req_r     <= in_data;
      exp_new_r <= exp_sum[64] ? '1 : exp_sum[63:0];
      min_exp_r <= '1;
      best_r    <= '0;
      hit_r     <= 1'b0;
      mac_r     <= '0;
      slot_r    <= '0;
    end else if (ctrl.cmp_vld) begin
      if (is_lookup) begin
        if (stat.stop) begin
          hit_r  <= 1'b1;
          mac_r  <= cur.mac;
          slot_r <= arpc_pkg::SLOT_W'(ctrl.cmp_idx);
        end
      end else if (cmp.ip_eq) begin
        best_r <= ctrl.cmp_idx;
      end else if (cmp.lt) begin
        best_r    <= ctrl.cmp_idx;
        min_exp_r <= cur.expiry;
      end
    end else if (ctrl.wr_en) begin
      slot_r <= arpc_pkg::SLOT_W'(best_r);
    end
  end

  // entry valid bits
  always_comb begin
    valid_nxt = valid_r;
    if (ctrl.accept && (in_data.kind == arpc_pkg::KIND_CLEAR)) begin
      valid_nxt = '0;
    end else if (ctrl.wr_en) begin
      valid_nxt[best_r] = 1'b1;
    end
  end

  // result register
  assign out_valid_nxt = ctrl.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data_r.hit       <= hit_r;
      out_data_r.found_mac <= mac_r;
      out_data_r.slot      <= slot_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/tb_arp_cache_with_expiry.sv
// Self-checking testbench for arp_cache_with_expiry: a directed table, then random
// lookup/remember/clear traffic over several lifetime settings, checked against a predictor.
// Depends on arpc_pkg and the arp_cache_with_expiry RTL.
`timescale 1ns / 1ps

module tb_arp_cache_with_expiry;
  import arpc_pkg::*;

  localparam logic [1:0]         KIND_UNUSED   = 2'd3;
  localparam logic [PADDR_W-1:0] LIFETIME_ADDR = PADDR_W'(4 * int'(REG_LIFETIME));
  localparam logic [63:0]        T_MAX         = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [47:0]        MAC_MAX       = 48'hFFFF_FFFF_FFFF;
  localparam int                 PHASES        = 6;
  localparam int                 PHASE_WORDS   = 150;
  localparam int                 HOLD_CYCLES   = 300;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the store and the lifetime register
  logic [31:0] cache_ip  [ENTRIES];
  logic [47:0] cache_mac [ENTRIES];
  logic [63:0] cache_exp [ENTRIES];
  logic [31:0] cache_life;

  out_word_t   arp_expect[$];
  dir_row_t    dir_tab[$];
  int          err_cnt;
  bit          idle_on;
  int          hold_req;
  int          hold_seen;
  int          stall_left;

  // random traffic state
  logic [31:0] ip_pool [12];
  logic [63:0] clock_ms;
  logic [31:0] last_ip;
  logic [63:0] last_now;

  arp_cache_with_expiry DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predict the result of one word and update the cache copy
  function automatic out_word_t arp_predict(input in_word_t w);
    out_word_t r;
    int        pick;
    bit        done;
    logic [64:0] sum;
    r    = '0;
    pick = 0;
    done = 1'b0;
    case (w.kind)
      KIND_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done && cache_ip[i] == w.ip_address && cache_exp[i] > w.now_ms) begin
            r.hit       = 1'b1;
            r.found_mac = cache_mac[i];
            r.slot      = SLOT_W'(i);
            done        = 1'b1;
          end
        end
      end
      KIND_REMEMBER: begin
        // first matching IP wins, else first entry with the smallest expiry
        for (int i = 0; i < ENTRIES; i++) begin
          if (!done) begin
            if (cache_ip[i] == w.ip_address) begin
              pick = i;
              done = 1'b1;
            end else if (cache_exp[i] < cache_exp[pick]) begin
              pick = i;
            end
          end
        end
        sum             = {1'b0, w.now_ms} + {33'd0, cache_life};
        cache_ip[pick]  = w.ip_address;
        cache_mac[pick] = w.hw_address;
        cache_exp[pick] = sum[64] ? T_MAX : sum[63:0];
        r.slot          = SLOT_W'(pick);
      end
      KIND_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          cache_ip[i]  = '0;
          cache_mac[i] = '0;
          cache_exp[i] = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t dir_chk(input logic [1:0] kind, input logic [31:0] ip,
                                       input logic [47:0] mac, input logic [63:0] now,
                                       input logic hit, input logic [47:0] fmac,
                                       input logic [SLOT_W-1:0] slot);
    dir_row_t d;
    d.word  = '{kind: kind, ip_address: ip, hw_address: mac, now_ms: now};
    d.typed = 1'b1;
    d.res   = '{hit: hit, found_mac: fmac, slot: slot};
    return d;
  endfunction

  function automatic dir_row_t dir_prd(input logic [1:0] kind, input logic [31:0] ip,
                                       input logic [47:0] mac, input logic [63:0] now);
    dir_row_t d;
    d.word  = '{kind: kind, ip_address: ip, hw_address: mac, now_ms: now};
    d.typed = 1'b0;
    d.res   = '0;
    return d;
  endfunction

  // Random word: mostly pooled addresses and a forward-moving clock so entries
  // hit, get refreshed, expire and get evicted
  function automatic in_word_t arp_random_word();
    in_word_t    w;
    int          r;
    int          r2;
    logic [31:0] step;
    r    = $urandom_range(0, 99);
    r2   = $urandom_range(0, 19);
    step = (cache_life == 0) ? 32'd4 : (cache_life >> 3) + 32'd1;
    if (r < 45)      w.kind = KIND_LOOKUP;
    else if (r < 93) w.kind = KIND_REMEMBER;
    else if (r < 97) w.kind = KIND_CLEAR;
    else             w.kind = KIND_UNUSED;
    w.ip_address = ($urandom_range(0, 9) == 0) ? $urandom : ip_pool[$urandom_range(0, 11)];
    w.hw_address = 48'({$urandom, $urandom});
    if (r2 == 0) begin
      w.now_ms = {$urandom, $urandom};
    end else if (r2 == 1) begin
      w.now_ms = T_MAX - 64'($urandom_range(0, 2));
    end else if (r2 == 2) begin
      w.now_ms = last_now;
    end else begin
      clock_ms = clock_ms + 64'($urandom_range(0, step));
      w.now_ms = clock_ms;
    end
    // re-lookup of the last remembered address at its own time
    if (w.kind == KIND_LOOKUP && $urandom_range(0, 9) < 3) begin
      w.ip_address = last_ip;
      w.now_ms     = last_now;
    end
    if (w.kind == KIND_REMEMBER) begin
      last_ip  = w.ip_address;
      last_now = w.now_ms;
    end
    return w;
  endfunction

  // Offer one word; the expectation is queued at the accepting edge
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t pred;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    pred = arp_predict(w);
    arp_expect.push_back(typed ? want : pred);
  endtask

  task automatic sender_gap();
    int n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (arp_expect.size() != 0) @(posedge clk);
  endtask

  // APB write of the lifetime register, then a read back
  task automatic lifetime_write(input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIFETIME_ADDR;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cache_life = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) begin
      $error("prdata: expected %h, got %h", val, prdata);
      err_cnt++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random stall bursts plus one long hold on request
  always @(negedge clk) begin : result_stall
    bit nxt;
    if (hold_seen != hold_req) begin
      hold_seen  = hold_req;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      nxt = 1'b1;
    end else begin
      nxt = 1'b0;
    end
    out_stall <= nxt;
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (arp_expect.size() == 0) begin
        $error("unexpected result word: %p", out_data);
        err_cnt++;
      end else begin
        e = arp_expect.pop_front();
        if (out_data.hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, out_data.hit);
          err_cnt++;
        end
        if (out_data.found_mac !== e.found_mac) begin
          $error("found_mac: expected %h, got %h", e.found_mac, out_data.found_mac);
          err_cnt++;
        end
        if (out_data.slot !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, out_data.slot);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stim
    dir_row_t    d;
    in_word_t    w;
    logic [31:0] life_plan [PHASES];
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    err_cnt    = 0;
    idle_on    = 1'b0;
    hold_req   = 0;
    hold_seen  = 0;
    stall_left = 0;
    cache_life = LIFETIME_RST;
    for (int i = 0; i < ENTRIES; i++) begin
      cache_ip[i]  = '0;
      cache_mac[i] = '0;
      cache_exp[i] = '0;
    end
    ip_pool[0] = 32'h0000_0000;
    ip_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) ip_pool[i] = $urandom;
    clock_ms = 64'd1000;
    last_ip  = ip_pool[2];
    last_now = clock_ms;
    life_plan[0] = 32'd0;
    life_plan[1] = 32'd1;
    life_plan[2] = 32'hFFFF_FFFF;
    life_plan[3] = $urandom_range(2, 100_000);
    life_plan[4] = LIFETIME_RST;
    life_plan[5] = 32'd1000;

    // directed rows, run at the reset lifetime of 60000
    dir_tab.push_back(dir_chk(KIND_LOOKUP, 32'h0, 48'h0, 64'd0, 1'b0, 48'h0, 3'd0));
    dir_tab.push_back(dir_chk(KIND_LOOKUP, 32'hFFFF_FFFF, MAC_MAX, T_MAX, 1'b0, 48'h0, 3'd0));
    dir_tab.push_back(dir_chk(KIND_REMEMBER, 32'h0A00_0001, MAC_MAX, 64'd0, 1'b0, 48'h0, 3'd0));
    dir_tab.push_back(dir_chk(KIND_LOOKUP, 32'h0A00_0001, 48'h0, 64'd59999, 1'b1, MAC_MAX, 3'd0));
    // expiry equal to now is no longer live
    dir_tab.push_back(dir_chk(KIND_LOOKUP, 32'h0A00_0001, 48'h0, 64'd60000, 1'b0, 48'h0, 3'd0));
    // IP zero matches a cleared entry
    dir_tab.push_back(dir_chk(KIND_REMEMBER, 32'h0, 48'h123, 64'd5, 1'b0, 48'h0, 3'd1));
    dir_tab.push_back(dir_prd(KIND_LOOKUP, 32'h0, 48'h0, 64'd0));
    // saturating expiry; smallest-expiry victim
    dir_tab.push_back(dir_chk(KIND_REMEMBER, 32'hFFFF_FFFF, 48'h0, T_MAX, 1'b0, 48'h0, 3'd2));
    dir_tab.push_back(dir_chk(KIND_LOOKUP, 32'hFFFF_FFFF, MAC_MAX, T_MAX - 1, 1'b1, 48'h0, 3'd2));
    dir_tab.push_back(dir_chk(KIND_LOOKUP, 32'hFFFF_FFFF, MAC_MAX, T_MAX, 1'b0, 48'h0, 3'd0));
    // unused kind changes nothing
    dir_tab.push_back(dir_chk(KIND_UNUSED, 32'h0A00_0001, MAC_MAX, T_MAX, 1'b0, 48'h0, 3'd0));
    dir_tab.push_back(dir_prd(KIND_LOOKUP, 32'h0A00_0001, 48'h0, 64'd1));
    dir_tab.push_back(dir_prd(KIND_REMEMBER, 32'h0A00_0001, 48'hAAAA_5555_AAAA, 64'd100));
    for (int i = 1; i <= 5; i++)
      dir_tab.push_back(dir_prd(KIND_REMEMBER, 32'hC0A8_0000 + 32'(i), 48'(i), 64'd200));
    // store full: evict
    dir_tab.push_back(dir_prd(KIND_REMEMBER, 32'hC0A8_0009, 48'h5555_AAAA_5555, 64'd300));
    dir_tab.push_back(dir_prd(KIND_REMEMBER, 32'h0, 48'h0, 64'd0));
    dir_tab.push_back(dir_prd(KIND_LOOKUP, 32'hC0A8_0003, 48'h0, 64'd60199));
    dir_tab.push_back(dir_chk(KIND_CLEAR, 32'h0A00_0001, MAC_MAX, T_MAX, 1'b0, 48'h0, 3'd0));
    dir_tab.push_back(dir_chk(KIND_LOOKUP, 32'h0A00_0001, 48'h0, 64'd0, 1'b0, 48'h0, 3'd0));
    // all expiries tie at zero: lowest index wins
    dir_tab.push_back(dir_chk(KIND_REMEMBER, 32'h5555_5555, 48'h5555_5555_5555, 64'd0,
                              1'b0, 48'h0, 3'd0));
    dir_tab.push_back(dir_chk(KIND_LOOKUP, 32'h0, 48'h0, 64'd0, 1'b0, 48'h0, 3'd0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_on = 1'b1;
    foreach (dir_tab[i]) begin
      d = dir_tab[i];
      send_word(d.word, d.typed, d.res);
      sender_gap();
    end
    drain();

    // random phases, one lifetime setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      lifetime_write(life_plan[ph]);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        idle_on = (ph != PHASES - 1) && !(k >= 50 && k < 80);
        w = arp_random_word();
        send_word(w, 1'b0, '0);
        if (ph == 1 && k == 20) hold_req++;
        if (ph == 2 && k == 60) drain();
        sender_gap();
      end
      drain();
    end

    repeat (16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/arpc_pkg.sv
design/arpc_ram.sv
design/arpc_cmp.sv
design/arpc_seq.sv
design/arp_cache_with_expiry.sv
tb/tb_arp_cache_with_expiry.sv
